/* design/espl_pkg.sv */
// shared types and constants of the encoder pid speed loop
package espl_pkg;

   localparam int CSR_ADDR_W = 3;

   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_P      = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_I      = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_D      = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_DRIVE_MAX   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_COUNT_LIMIT = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_DEADBAND    = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_OVR_SPEED   = 3'd6;

   localparam logic [31:0] GAIN_P_RST      = 32'd16777216;
   localparam logic [31:0] GAIN_I_RST      = 32'd1678;
   localparam logic [31:0] GAIN_D_RST      = 32'd134217728;
   localparam logic [15:0] DRIVE_MAX_RST   = 16'd1000;
   localparam logic [14:0] COUNT_LIMIT_RST = 15'd100;
   localparam logic [15:0] DEADBAND_RST    = 16'd2;
   localparam logic [15:0] OVR_SPEED_RST   = 16'd9;

   // integral accumulator ceiling and integral term ceiling (2^60)
   localparam logic [39:0] SUM_MAX    = 40'hFF_FFFF_FFFF;
   localparam logic [60:0] ITERM_CAP  = 61'h1000_0000_0000_0000;
   // ceil(2^18 / 5), exact divide by five for 16-bit values
   localparam logic [16:0] DIV5_RECIP = 17'd52429;

   typedef struct packed {
      logic [31:0] gain_p;
      logic [31:0] gain_i;
      logic [31:0] gain_d;
      logic [15:0] drive_max;
      logic [14:0] count_limit;
      logic [15:0] deadband;
      logic [15:0] overrange_speed;
   } cfg_type;

   typedef struct packed {
      logic               direction;
      logic [15:0]        speed;
      logic [16:0]        error_mag;
      logic               setpoint_reload;
      logic               motor_reload;
      logic signed [15:0] setpoint_out;
      logic signed [31:0] position_out;
      logic               setpoint_down_out;
      logic               motor_down_out;
   } echo_type;

   typedef struct packed {
      echo_type           echo;
      logic signed [17:0] ediff;
      logic [39:0]        esum;
      logic               hold_zero;
   } front_type;

   typedef struct packed {
      echo_type    echo;
      logic [15:0] drive;
      logic [13:0] pwm_compare;
   } result_type;

endpackage

/* design/espl_csr.sv */
// configuration registers of the encoder pid speed loop
module espl_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wen,
   input  logic [espl_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [31:0]                         csr_wdata,
   output espl_pkg::cfg_type                   cfg_ff
);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p          <= espl_pkg::GAIN_P_RST;
         cfg_ff.gain_i          <= espl_pkg::GAIN_I_RST;
         cfg_ff.gain_d          <= espl_pkg::GAIN_D_RST;
         cfg_ff.drive_max       <= espl_pkg::DRIVE_MAX_RST;
         cfg_ff.count_limit     <= espl_pkg::COUNT_LIMIT_RST;
         cfg_ff.deadband        <= espl_pkg::DEADBAND_RST;
         cfg_ff.overrange_speed <= espl_pkg::OVR_SPEED_RST;
      end else if (csr_wen) begin
         unique case (csr_addr)
            espl_pkg::CSR_GAIN_P:      cfg_ff.gain_p          <= csr_wdata;
            espl_pkg::CSR_GAIN_I:      cfg_ff.gain_i          <= csr_wdata;
            espl_pkg::CSR_GAIN_D:      cfg_ff.gain_d          <= csr_wdata;
            espl_pkg::CSR_DRIVE_MAX:   cfg_ff.drive_max       <= csr_wdata[15:0];
            espl_pkg::CSR_COUNT_LIMIT: cfg_ff.count_limit     <= csr_wdata[14:0];
            espl_pkg::CSR_DEADBAND:    cfg_ff.deadband        <= csr_wdata[15:0];
            espl_pkg::CSR_OVR_SPEED:   cfg_ff.overrange_speed <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

endmodule

/* design/espl_front.sv */
// input register, counter clamp, speed and error, loop state update
module espl_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load_s1,
   input  logic                 load_s2,
   input  logic                 advance,
   input  logic signed [15:0]   setpoint_count,
   input  logic signed [31:0]   motor_count,
   input  logic                 setpoint_down,
   input  logic                 motor_down,
   input  espl_pkg::cfg_type    cfg,
   output espl_pkg::front_type  s2_ff
);

   logic signed [15:0] sp_ff;
   logic signed [31:0] mc_ff;
   logic               sp_dn_ff;
   logic               mc_dn_ff;

   logic [39:0]        error_sum_ff, error_sum_in;
   logic [16:0]        last_error_ff;
   logic signed [31:0] last_position_ff;
   logic signed [15:0] last_setpoint_ff;

   espl_pkg::front_type s2_in;

   logic signed [32:0] lim_w, nlim_w, sp_w, mc_w, sp_c, mc_c, pos_diff;
   logic [32:0]        pos_abs;
   logic [15:0]        speed;
   logic signed [17:0] sp18, err_diff;
   logic [17:0]        err_abs;
   logic [16:0]        err;
   logic               sp_rl, mc_rl, hold_zero;
   logic [40:0]        sum_w;

   always_comb begin
      lim_w  = $signed({18'd0, cfg.count_limit});
      nlim_w = -lim_w;
      sp_w   = {{17{sp_ff[15]}}, sp_ff};
      mc_w   = {mc_ff[31], mc_ff};
      sp_c   = sp_w;
      mc_c   = mc_w;
      sp_rl  = 1'b0;
      mc_rl  = 1'b0;

      // only the first out-of-range case is clamped
      if (sp_w > lim_w) begin
         sp_c  = lim_w;
         sp_rl = 1'b1;
      end else if (mc_w > lim_w) begin
         mc_c  = lim_w;
         mc_rl = 1'b1;
      end else if (sp_w < nlim_w) begin
         sp_c  = nlim_w;
         sp_rl = 1'b1;
      end else if (mc_w < nlim_w) begin
         mc_c  = nlim_w;
         mc_rl = 1'b1;
      end

      pos_diff = mc_c - {last_position_ff[31], last_position_ff};
      pos_abs  = pos_diff[32] ? -pos_diff : pos_diff;
      if (mc_c < lim_w) begin
         speed = (|pos_abs[32:16]) ? 16'hFFFF : pos_abs[15:0];
      end else begin
         speed = cfg.overrange_speed;
      end

      sp18     = sp_c[17:0];
      err_diff = sp18 - $signed({2'b00, speed});
      err_abs  = err_diff[17] ? -err_diff : err_diff;
      err      = err_abs[16:0];

      hold_zero = (err < {1'b0, cfg.deadband}) && (sp_c[15:0] == last_setpoint_ff);

      sum_w        = {1'b0, (hold_zero ? 40'd0 : error_sum_ff)} + {24'd0, err};
      error_sum_in = sum_w[40] ? espl_pkg::SUM_MAX : sum_w[39:0];

      s2_in.echo.direction         = sp_ff[15];
      s2_in.echo.speed             = speed;
      s2_in.echo.error_mag         = err;
      s2_in.echo.setpoint_reload   = sp_rl;
      s2_in.echo.motor_reload      = mc_rl;
      s2_in.echo.setpoint_out      = sp_c[15:0];
      s2_in.echo.position_out      = mc_c[31:0];
      s2_in.echo.setpoint_down_out = sp_dn_ff;
      s2_in.echo.motor_down_out    = mc_dn_ff;
      s2_in.ediff                  = $signed({1'b0, err}) - $signed({1'b0, last_error_ff});
      s2_in.esum                   = error_sum_ff;
      s2_in.hold_zero              = hold_zero;
   end

   always_ff @(posedge clock) begin
      if (load_s1) begin
         sp_ff    <= setpoint_count;
         mc_ff    <= motor_count;
         sp_dn_ff <= setpoint_down;
         mc_dn_ff <= motor_down;
      end
      if (load_s2) begin
         s2_ff <= s2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         error_sum_ff     <= '0;
         last_error_ff    <= '0;
         last_position_ff <= '0;
         last_setpoint_ff <= '0;
      end else if (advance) begin
         error_sum_ff     <= error_sum_in;
         last_error_ff    <= err;
         last_position_ff <= mc_c[31:0];
         last_setpoint_ff <= sp_c[15:0];
      end
   end

endmodule

/* design/espl_pid.sv */
// pid products, sum, drive clamp and divide by five
module espl_pid (
   input  logic                 clock,
   input  logic [3:0]           load,
   input  espl_pkg::front_type  s2,
   input  espl_pkg::cfg_type    cfg,
   output espl_pkg::result_type result_ff
);

   // stage 3: products
   espl_pkg::echo_type s3_echo_ff;
   logic               s3_zero_ff;
   logic [48:0]        pterm_ff, pterm_in;
   logic signed [50:0] dterm_ff, dterm_in;
   logic [63:0]        ilo_ff, ilo_in;
   logic [39:0]        ihi_ff, ihi_in;

   // stage 4: integral term and p+d
   espl_pkg::echo_type s4_echo_ff;
   logic               s4_zero_ff;
   logic [71:0]        iprod;
   logic [60:0]        iterm_ff, iterm_in;
   logic signed [51:0] pd_ff, pd_in;

   // stage 5: clamp
   espl_pkg::echo_type s5_echo_ff;
   logic signed [62:0] total;
   logic signed [62:0] top;
   logic [15:0]        drive_ff, drive_in;

   // stage 6: divide by five
   logic [32:0]        pwm_prod;

   always_comb begin
      pterm_in = cfg.gain_p * s2.echo.error_mag;
      dterm_in = $signed({1'b0, cfg.gain_d}) * s2.ediff;
      ilo_in   = cfg.gain_i * s2.esum[31:0];
      ihi_in   = cfg.gain_i * s2.esum[39:32];

      iprod    = {ihi_ff, 32'd0} + {8'd0, ilo_ff};
      iterm_in = (iprod > {11'd0, espl_pkg::ITERM_CAP}) ? espl_pkg::ITERM_CAP : iprod[60:0];
      pd_in    = $signed({3'b000, pterm_ff}) + dterm_ff;

      total = $signed({2'b00, iterm_ff}) + pd_ff;
      top   = $signed({23'd0, cfg.drive_max, 24'd0});
      if (s4_zero_ff || total < 0) begin
         drive_in = '0;
      end else if (total > top) begin
         drive_in = cfg.drive_max;
      end else begin
         drive_in = total[39:24];
      end

      pwm_prod = drive_ff * espl_pkg::DIV5_RECIP;
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         s3_echo_ff <= s2.echo;
         s3_zero_ff <= s2.hold_zero;
         pterm_ff   <= pterm_in;
         dterm_ff   <= dterm_in;
         ilo_ff     <= ilo_in;
         ihi_ff     <= ihi_in;
      end
      if (load[1]) begin
         s4_echo_ff <= s3_echo_ff;
         s4_zero_ff <= s3_zero_ff;
         iterm_ff   <= iterm_in;
         pd_ff      <= pd_in;
      end
      if (load[2]) begin
         s5_echo_ff <= s4_echo_ff;
         drive_ff   <= drive_in;
      end
      if (load[3]) begin
         result_ff.echo        <= s5_echo_ff;
         result_ff.drive       <= drive_ff;
         result_ff.pwm_compare <= pwm_prod[31:18];
      end
   end

endmodule

/* design/encoder_pid_speed_loop.sv */
// top level of the encoder pid speed loop
//
//   port group  dir  word                                    handshake
//   req_*       in   setpoint, motor count, count-down flags tvalid/tready
//   rsp_*       out  direction, drive, pwm, speed, error...  tvalid/tready
//   csr_*       in   register index and data                 csr_wen only
//
// one word in and one word out per cycle while rsp_tready is high; six
// registers deep, rsp_tvalid high once a word is in the last (input reg,
// clamp/speed/error, products, integral cap and p+d sum, drive clamp,
// divide by five into the output reg)
// the loop state (error sum, last error, last position, last setpoint) is
// updated as a word enters the clamp/error stage, so the next word sees it
// synchronous reset clears the stage valids, the loop state and the registers
// back to their defaults
// a low rsp_tready holds the output word; earlier stages still take words
// until every bubble in the pipe is filled
module encoder_pid_speed_loop (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata: [15:0] setpoint_count, [47:16] motor_count,
   //            [48] setpoint_down, [49] motor_down, [55:50] zero
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [55:0]                       req_tdata,
   // rsp_tdata: [0] direction, [16:1] drive, [30:17] pwm_compare,
   //            [46:31] speed, [63:47] error_mag, [64] setpoint_reload,
   //            [65] motor_reload, [81:66] setpoint_out, [113:82] position_out,
   //            [114] setpoint_down_out, [115] motor_down_out, [119:116] zero
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [119:0]                      rsp_tdata,
   input  logic                              csr_wen,
   input  logic [espl_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [31:0]                       csr_wdata
);

   espl_pkg::cfg_type    cfg;
   espl_pkg::front_type  s2;
   espl_pkg::result_type result;

   // stage valids 1..6 and the per-stage load enables
   logic [6:1] valid_ff, valid_in;
   logic [6:1] upstream;
   logic [7:1] take;

   always_comb begin
      take[7] = rsp_tready;
      for (int k = 6; k >= 1; k--) begin
         take[k] = !valid_ff[k] || take[k+1];
      end
      upstream = {valid_ff[5:1], req_tvalid};
      for (int k = 1; k <= 6; k++) begin
         valid_in[k] = take[k] ? upstream[k] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = take[1];
   assign rsp_tvalid = valid_ff[6];

   espl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg_ff    (cfg)
   );

   // state moves forward only when a real word leaves stage 1
   espl_front u_front (
      .clock          (clock),
      .reset          (reset),
      .load_s1        (take[1]),
      .load_s2        (take[2]),
      .advance        (valid_ff[1] && take[2]),
      .setpoint_count (req_tdata[15:0]),
      .motor_count    (req_tdata[47:16]),
      .setpoint_down  (req_tdata[48]),
      .motor_down     (req_tdata[49]),
      .cfg            (cfg),
      .s2_ff          (s2)
   );

   espl_pid u_pid (
      .clock     (clock),
      .load      (take[6:3]),
      .s2        (s2),
      .cfg       (cfg),
      .result_ff (result)
   );

   assign rsp_tdata = {4'd0,
                       result.echo.motor_down_out,
                       result.echo.setpoint_down_out,
                       result.echo.position_out,
                       result.echo.setpoint_out,
                       result.echo.motor_reload,
                       result.echo.setpoint_reload,
                       result.echo.error_mag,
                       result.echo.speed,
                       result.pwm_compare,
                       result.drive,
                       result.echo.direction};

endmodule

/* design/espl_checker.sv */
// port-level checks of the encoder pid speed loop and their bind
module espl_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [119:0] rsp_tdata
);

   logic [19:0] drive_w;
   logic [19:0] pwm_x5;

   assign drive_w = {4'd0, rsp_tdata[16:1]};
   assign pwm_x5  = {6'd0, rsp_tdata[30:17]} * 20'd5;

   // no word is presented right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // a stalled word stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled rsp word changed");

   // pwm compare is drive divided by five, truncated
   a_pwm_div5: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (pwm_x5 <= drive_w) && (drive_w < pwm_x5 + 20'd5))
      else $error("pwm_compare does not match drive / 5");

   // at most one counter is reloaded per tick
   a_one_reload: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[64] && rsp_tdata[65]))
      else $error("both reload flags set");

endmodule

bind encoder_pid_speed_loop espl_checker u_espl_checker (.*);
